>>> hdl/travel_time_distance_over_speed_assert.svh
// assertion macros for the travel time block
`ifndef TRAVEL_TIME_DISTANCE_OVER_SPEED_ASSERT_SVH
`define TRAVEL_TIME_DISTANCE_OVER_SPEED_ASSERT_SVH

// property must hold on every rising clock edge outside reset
`define TT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ttd_pkg.sv
package ttd_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DiffW  = 25;
  localparam int unsigned SqW    = 50;
  localparam int unsigned RootW  = 33;
  localparam int unsigned RemW   = 35;
  localparam int unsigned QuoW   = 33;
  localparam logic [SpeedW-1:0] SpeedOne = 16'd256;

  typedef struct packed {
    logic signed [PosW-1:0] pos_a_x;
    logic signed [PosW-1:0] pos_a_y;
    logic signed [PosW-1:0] pos_b_x;
    logic signed [PosW-1:0] pos_b_y;
    logic [SpeedW-1:0]      speed;
  } in_item_t;

  typedef struct packed {
    logic [TimeW-1:0] travel_time;
    logic             saturated;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic [SqW-1:0]    sq;
    logic [SpeedW-1:0] divisor;
  } work_t;

endpackage

>>> hdl/ttd_front.sv
module ttd_front import ttd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     wk_valid_o,
  input  logic     wk_ready_i,
  output work_t    wk_data_o
);

  logic              s1_valid_q, s2_valid_q;
  logic [DiffW-2:0]  dx_q, dy_q;
  logic [SpeedW-1:0] sp1_q;
  logic [2*DiffW-3:0] dx2_q, dy2_q;
  logic [SpeedW-1:0] sp2_q;
  logic              adv2, adv1;
  logic signed [DiffW-1:0] dx_d, dy_d;

  assign adv2 = !s2_valid_q || wk_ready_i;
  assign adv1 = !s1_valid_q || adv2;
  assign in_ready_o = adv1;

  always_comb begin
    dx_d = DiffW'(in_data_i.pos_a_x) - DiffW'(in_data_i.pos_b_x);
    dy_d = DiffW'(in_data_i.pos_a_y) - DiffW'(in_data_i.pos_b_y);
    if (dx_d < 0) dx_d = -dx_d;
    if (dy_d < 0) dy_d = -dy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      dx_q  <= dx_d[DiffW-2:0];
      dy_q  <= dy_d[DiffW-2:0];
      sp1_q <= (in_data_i.speed == '0) ? SpeedOne : in_data_i.speed;
    end
    if (adv2 && s1_valid_q) begin
      dx2_q <= dx_q * dx_q;
      dy2_q <= dy_q * dy_q;
      sp2_q <= sp1_q;
    end
  end

  assign wk_valid_o       = s2_valid_q;
  assign wk_data_o.sq      = SqW'(dx2_q) + SqW'(dy2_q);
  assign wk_data_o.divisor = sp2_q;

endmodule

>>> hdl/ttd_queue.sv
module ttd_queue import ttd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  work_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output work_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t           mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

>>> hdl/ttd_back.sv
module ttd_back import ttd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wk_valid_i,
  output logic      wk_ready_o,
  input  work_t     wk_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // RootW sqrt stages, then QuoW divide stages, one digit per stage
  localparam int unsigned SqSt  = RootW;
  localparam int unsigned DvSt  = QuoW;
  localparam int unsigned DRemW = SpeedW + 1;

  logic              adv;
  logic              sv_q [1:SqSt];
  logic [SqW-1:0]    sq_q [1:SqSt];
  logic [RootW-1:0]  rt_q [1:SqSt];
  logic [RemW-1:0]   rm_q [1:SqSt];
  logic [SpeedW-1:0] sd_q [1:SqSt];
  logic              dv_q [1:DvSt];
  logic [RootW-1:0]  nu_q [1:DvSt];
  logic [QuoW-1:0]   qo_q [1:DvSt];
  logic [DRemW-1:0]  dr_q [1:DvSt];
  logic [SpeedW-1:0] dd_q [1:DvSt];

  assign adv = !out_valid_o || out_ready_i;
  assign wk_ready_o = adv;

  for (genvar g = 0; g < SqSt; g++) begin : g_sqrt
    localparam int I = RootW - 1 - g;
    logic              v_in;
    logic [SqW-1:0]    sq_in;
    logic [RootW-1:0]  rt_in;
    logic [RemW-1:0]   rm_in;
    logic [SpeedW-1:0] sd_in;
    logic [1:0]        pair;
    logic [RemW-1:0]   rem, trial;
    if (g == 0) begin : g_head
      assign v_in  = wk_valid_i;
      assign sq_in = wk_data_i.sq;
      assign rt_in = '0;
      assign rm_in = '0;
      assign sd_in = wk_data_i.divisor;
    end else begin : g_body
      assign v_in  = sv_q[g];
      assign sq_in = sq_q[g];
      assign rt_in = rt_q[g];
      assign rm_in = rm_q[g];
      assign sd_in = sd_q[g];
    end
    // the lowest eight digit pairs come from the 2^16 scaling
    if (I >= 8) begin : g_pair
      assign pair = sq_in[2*(I-8) +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end
    assign rem   = {rm_in[RemW-3:0], pair};
    assign trial = {rt_in[RemW-3:0], 2'b01};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[g+1] <= 1'b0;
      else if (adv) sv_q[g+1] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[g+1] <= sq_in;
        sd_q[g+1] <= sd_in;
        if (rem >= trial) begin
          rm_q[g+1] <= rem - trial;
          rt_q[g+1] <= {rt_in[RootW-2:0], 1'b1};
        end else begin
          rm_q[g+1] <= rem;
          rt_q[g+1] <= {rt_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  for (genvar g = 0; g < DvSt; g++) begin : g_div
    localparam int I = QuoW - 1 - g;
    logic              v_in;
    logic [RootW-1:0]  nu_in;
    logic [QuoW-1:0]   qo_in;
    logic [DRemW-1:0]  dr_in;
    logic [SpeedW-1:0] dd_in;
    logic [DRemW-1:0]  r;
    if (g == 0) begin : g_head
      assign v_in  = sv_q[SqSt];
      assign nu_in = rt_q[SqSt];
      assign qo_in = '0;
      assign dr_in = '0;
      assign dd_in = sd_q[SqSt];
    end else begin : g_body
      assign v_in  = dv_q[g];
      assign nu_in = nu_q[g];
      assign qo_in = qo_q[g];
      assign dr_in = dr_q[g];
      assign dd_in = dd_q[g];
    end
    assign r = {dr_in[DRemW-2:0], nu_in[I]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[g+1] <= 1'b0;
      else if (adv) dv_q[g+1] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        nu_q[g+1] <= nu_in;
        dd_q[g+1] <= dd_in;
        if (r >= {1'b0, dd_in}) begin
          dr_q[g+1] <= r - {1'b0, dd_in};
          qo_q[g+1] <= {qo_in[QuoW-2:0], 1'b1};
        end else begin
          dr_q[g+1] <= r;
          qo_q[g+1] <= {qo_in[QuoW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid_o            = dv_q[DvSt];
  assign out_data_o.saturated   = qo_q[DvSt][QuoW-1];
  assign out_data_o.travel_time = qo_q[DvSt][QuoW-1] ? '1 : qo_q[DvSt][TimeW-1:0];

endmodule

>>> hdl/travel_time_distance_over_speed.sv
// channel | direction | payload
// in      | input     | in_item_t: two Q16.8 points and a Q8.8 speed
// out     | output    | out_item_t: Q24.8 travel time and saturation flag
// one transaction per cycle sustained while out_ready_i holds; 2 front stages, the queue storage,
// 66 back stages (one per square-root digit, one per quotient digit)
// reset clears all valid flags and queue pointers, no data is cleared
// an output stall freezes the back pipeline; the queue lets the front keep going
// until it fills, then in_ready_o drops
module travel_time_distance_over_speed import ttd_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic  fw_valid, fw_ready, bk_valid, bk_ready;
  work_t fw_data, bk_data;

  ttd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .wk_valid_o(fw_valid), .wk_ready_i(fw_ready), .wk_data_o(fw_data)
  );

  ttd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fw_valid), .wr_ready_o(fw_ready), .wr_data_i(fw_data),
    .rd_valid_o(bk_valid), .rd_ready_i(bk_ready), .rd_data_o(bk_data)
  );

  ttd_back u_back (
    .clk_i, .rst_ni,
    .wk_valid_i(bk_valid), .wk_ready_o(bk_ready), .wk_data_i(bk_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

`include "travel_time_distance_over_speed_assert.svh"

  `TT_ASSERT(a_sat_max, !out_valid_o || !out_data_o.saturated || (&out_data_o.travel_time), "saturation without max")
  `TT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `TT_ASSERT(a_q_nonzero_div, !bk_valid || (bk_data.divisor != '0), "zero divisor reached back end")

endmodule

>>> dv/travel_time_distance_over_speed_tb.sv
`timescale 1ns / 1ps

module travel_time_distance_over_speed_tb;
  import ttd_pkg::*;

  localparam int unsigned NumRandom = 1600;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned HoldCycles = 1000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  out_item_t time_queue[$];
  int unsigned mismatches;
  int unsigned idle_cycles = 0;
  bit          hold_off;

  travel_time_distance_over_speed i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // bit-serial square root of q * 2^16, then truncating division
  function automatic out_item_t calc_travel_time(in_item_t it);
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] trial;
    logic [63:0] pair;
    logic [63:0] div;
    logic [63:0] quo;
    out_item_t r;
    dx = DiffW'(it.pos_a_x) - DiffW'(it.pos_b_x);
    dy = DiffW'(it.pos_a_y) - DiffW'(it.pos_b_y);
    ax = dx < 0 ? 64'(-dx) : 64'(dx);
    ay = dy < 0 ? 64'(-dy) : 64'(dy);
    sq = ax * ax + ay * ay;
    root = '0;
    rem = '0;
    for (int i = 32; i >= 0; i--) begin
      pair = (i >= 8) ? ((sq >> (2 * (i - 8))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    div = (it.speed == '0) ? 64'(SpeedOne) : 64'(it.speed);
    quo = root / div;
    if (quo > 64'hFFFF_FFFF) begin
      r.travel_time = '1;
      r.saturated   = 1'b1;
    end else begin
      r.travel_time = quo[TimeW-1:0];
      r.saturated   = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  function automatic in_item_t mk(int ax, int ay, int bx, int by, int sp);
    in_item_t it;
    it.pos_a_x = ax[23:0];
    it.pos_a_y = ay[23:0];
    it.pos_b_x = bx[23:0];
    it.pos_b_y = by[23:0];
    it.speed   = sp[15:0];
    return it;
  endfunction

  function automatic logic [23:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(0, 2047)) - 24'd1024;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 8));
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // directed rows; check marks rows whose result is typed in
  typedef struct {
    in_item_t  item;
    bit        check;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{mk(0, 0, 0, 0, 0), 1'b1, '{32'd0, 1'b0}},
    '{mk(1000, -7, 1000, -7, 1), 1'b1, '{32'd0, 1'b0}},
    '{mk(768, 0, 0, 0, 256), 1'b1, '{32'd768, 1'b0}},
    '{mk(768, 1024, 0, 0, 256), 1'b1, '{32'd1280, 1'b0}},
    '{mk(768, 0, 0, 0, 0), 1'b1, '{32'd768, 1'b0}},
    '{mk(768, 0, 0, 0, 512), 1'b1, '{32'd384, 1'b0}},
    '{mk(8388607, 8388607, -8388608, -8388608, 1), 1'b1, '{32'hFFFFFFFF, 1'b1}},
    '{mk(-8388608, 0, 8388607, 0, 1), 1'b1, '{32'hFFFFFF00, 1'b0}},
    '{mk(8388607, 8388607, -8388608, -8388608, 65535), 1'b0, '{32'd0, 1'b0}},
    '{mk(8388607, 8388607, -8388608, -8388608, 0), 1'b0, '{32'd0, 1'b0}},
    '{mk(-8388608, -8388608, 8388607, 8388607, 256), 1'b0, '{32'd0, 1'b0}},
    '{mk(16777, 0, 0, 0, 1), 1'b1, '{32'd4294912, 1'b0}},
    '{mk(1, 1, 0, 0, 65535), 1'b1, '{32'd0, 1'b0}},
    '{mk(0, 8388607, 0, -8388608, 255), 1'b0, '{32'd0, 1'b0}},
    '{mk(300, -400, -300, 400, 3), 1'b0, '{32'd0, 1'b0}},
    '{mk(-1, -1, 1, 1, 256), 1'b0, '{32'd0, 1'b0}}
  };

  // valid drops only when a gap follows, so each edge sees one assignment
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // expectations enter the queue at the accepting edge
  always @(posedge clk_i) begin
    if (in_valid && in_ready) time_queue.push_back(calc_travel_time(in_data));
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (out_valid && out_ready) begin
      if (time_queue.size() == 0) begin
        report_mismatch("unexpected transaction", out_data, 0);
      end else begin
        want = time_queue.pop_front();
        if (out_data.travel_time !== want.travel_time)
          report_mismatch("travel_time", out_data.travel_time, want.travel_time);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", out_data.saturated, want.saturated);
      end
    end
  end

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid && !hold_off);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    mismatches = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].check) begin
        if (calc_travel_time(dir_rows[i].item) != dir_rows[i].want)
          report_mismatch("directed row", i, 0);
      end
      send_item(dir_rows[i].item);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 400) hold_off = 1'b1;
      it.pos_a_x = rand_pos();
      it.pos_a_y = rand_pos();
      it.pos_b_x = rand_pos();
      it.pos_b_y = rand_pos();
      // near points to probe small distances
      if ($urandom_range(0, 3) == 0) begin
        it.pos_b_x = it.pos_a_x + 24'($urandom_range(0, 64)) - 24'd32;
        it.pos_b_y = it.pos_a_y + 24'($urandom_range(0, 64)) - 24'd32;
      end
      it.speed = rand_speed();
      // burst stretches with no sender gaps
      if ((n / 100) % 3 == 2) begin
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk_i); while (!in_ready);
      end else begin
        send_item(it);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk_i);

    while (time_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && time_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
